// ===== rtl/lhfg_pkg.sv =====
// ----------------------------------------------------------------------------
// lhfg_pkg
// Shared constants, codes and control types for the low-hash feature
// generator: window size, hash constants, register indexes, command/status.
// ----------------------------------------------------------------------------
`default_nettype none

package lhfg_pkg;

  // window of marker ids hashed per feature
  localparam int WINDOW_MARKERS = 4;
  localparam int WIN_BITS       = WINDOW_MARKERS * 32;
  localparam int NUM_BLK        = WINDOW_MARKERS / 2;   // 8-byte blocks
  localparam bit HAS_TAIL       = (WINDOW_MARKERS % 2) != 0;
  localparam int BLK_W          = (NUM_BLK > 1) ? $clog2(NUM_BLK) : 1;

  localparam logic [63:0] MH_MUL   = 64'hc6a4a7935bd1e995;
  localparam int          MH_SHIFT = 47;
  localparam logic [63:0] LEN_MUL  = 64'(WINDOW_MARKERS * 4) * MH_MUL;

  localparam int          SEED_W      = 14;
  localparam logic [13:0] SEED_FACTOR = 14'd37;

  // configuration port
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 64;
  localparam logic [CFG_IDX_W-1:0] CFG_HASH_THRESHOLD = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOG2_BUCKETS   = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ITERATION      = 8'd2;

  localparam logic [5:0] LOG2_BUCKETS_RST = 6'd20;

  typedef enum logic [3:0] {
    OP_NONE  = 4'd0,
    OP_INIT  = 4'd1,  // h = seed ^ len*m
    OP_LOADK = 4'd2,  // k = next 8-byte block
    OP_MULK  = 4'd3,  // k *= m, three phases
    OP_XSK   = 4'd4,  // k ^= k >> r
    OP_XHK   = 4'd5,  // h ^= k
    OP_MULH  = 4'd6,  // h *= m, three phases
    OP_TAIL  = 4'd7,  // h ^= trailing id
    OP_XSH   = 4'd8   // h ^= h >> r
  } op_t;

  typedef struct packed {
    logic             accept;
    op_t              op;
    logic [1:0]       phase;
    logic [BLK_W-1:0] blk;
    logic             out_load;
  } cmd_t;

  typedef struct packed {
    logic go;        // accepted word yields a feature to hash
    logic low;       // hash below threshold
    logic out_free;  // output register can take a word
  } status_t;

endpackage

`default_nettype wire

// ===== rtl/lhfg_if.sv =====
// ----------------------------------------------------------------------------
// lhfg channel interfaces
// Valid/ready channels for marker input, feature output and configuration.
// ----------------------------------------------------------------------------
`default_nettype none

interface lhfg_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] kmer_id;
  logic        read_start;
  logic        read_palindromic;

  modport source (output valid, kmer_id, read_start, read_palindromic, input ready);
  modport sink   (input valid, kmer_id, read_start, read_palindromic, output ready);
endinterface

interface lhfg_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] hash_value;
  logic [31:0] feature_ordinal;
  logic [31:0] bucket_id;

  modport source (output valid, hash_value, feature_ordinal, bucket_id, input ready);
  modport sink   (input valid, hash_value, feature_ordinal, bucket_id, output ready);
endinterface

interface lhfg_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [63:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/lhfg_ctrl.sv =====
// ----------------------------------------------------------------------------
// lhfg_ctrl
// Sequencer for the MurmurHash64A steps over the marker window.
// ----------------------------------------------------------------------------
`default_nettype none

module lhfg_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire lhfg_pkg::status_t sts,
  output lhfg_pkg::cmd_t        cmd
);
  import lhfg_pkg::*;

  typedef enum logic [13:0] {
    S_IDLE  = 14'b00000000000001,
    S_INIT  = 14'b00000000000010,
    S_LOADK = 14'b00000000000100,
    S_MK1   = 14'b00000000001000,
    S_XK    = 14'b00000000010000,
    S_MK2   = 14'b00000000100000,
    S_XH    = 14'b00000001000000,
    S_MH    = 14'b00000010000000,
    S_TAIL  = 14'b00000100000000,
    S_MT    = 14'b00001000000000,
    S_F1    = 14'b00010000000000,
    S_MF    = 14'b00100000000000,
    S_F2    = 14'b01000000000000,
    S_OUT   = 14'b10000000000000
  } state_t;

  localparam logic [BLK_W-1:0] BLK_LAST = BLK_W'((NUM_BLK > 0) ? NUM_BLK - 1 : 0);

  state_t           state_r, state_nxt;
  logic [1:0]       ph_r, ph_nxt;
  logic [BLK_W-1:0] blk_r, blk_nxt;
  logic             in_mul;
  logic             mul_done;
  state_t           after_blocks;

  assign in_ready = (state_r == S_IDLE);
  assign in_mul   = (state_r == S_MK1) || (state_r == S_MK2) || (state_r == S_MH) ||
                    (state_r == S_MT)  || (state_r == S_MF);
  assign mul_done = (ph_r == 2'd2);
  assign after_blocks = HAS_TAIL ? S_TAIL : S_F1;

  always_comb begin
    state_nxt = state_r;
    blk_nxt   = blk_r;
    ph_nxt    = (in_mul && !mul_done) ? ph_r + 2'd1 : 2'd0;
    unique case (state_r)
      S_IDLE: begin
        blk_nxt = '0;
        if (in_valid && sts.go) state_nxt = S_INIT;
      end
      S_INIT:  state_nxt = (NUM_BLK > 0) ? S_LOADK : after_blocks;
      S_LOADK: state_nxt = S_MK1;
      S_MK1:   if (mul_done) state_nxt = S_XK;
      S_XK:    state_nxt = S_MK2;
      S_MK2:   if (mul_done) state_nxt = S_XH;
      S_XH:    state_nxt = S_MH;
      S_MH: begin
        if (mul_done) begin
          if (blk_r == BLK_LAST) begin
            state_nxt = after_blocks;
          end else begin
            blk_nxt   = blk_r + 1'b1;
            state_nxt = S_LOADK;
          end
        end
      end
      S_TAIL:  state_nxt = S_MT;
      S_MT:    if (mul_done) state_nxt = S_F1;
      S_F1:    state_nxt = S_MF;
      S_MF:    if (mul_done) state_nxt = S_F2;
      S_F2:    state_nxt = S_OUT;
      S_OUT:   if (!sts.low || sts.out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd.accept   = in_valid && (state_r == S_IDLE);
    cmd.phase    = ph_r;
    cmd.blk      = blk_r;
    cmd.out_load = (state_r == S_OUT) && sts.low && sts.out_free;
    unique case (state_r)
      S_INIT:                  cmd.op = OP_INIT;
      S_LOADK:                 cmd.op = OP_LOADK;
      S_MK1, S_MK2:            cmd.op = OP_MULK;
      S_XK:                    cmd.op = OP_XSK;
      S_XH:                    cmd.op = OP_XHK;
      S_MH, S_MT, S_MF:        cmd.op = OP_MULH;
      S_TAIL:                  cmd.op = OP_TAIL;
      S_F1, S_F2:              cmd.op = OP_XSH;
      default:                 cmd.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ph_r    <= 2'd0;
      blk_r   <= '0;
    end else begin
      state_r <= state_nxt;
      ph_r    <= ph_nxt;
      blk_r   <= blk_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/lhfg_dpath.sv =====
// ----------------------------------------------------------------------------
// lhfg_dpath
// Marker window, read counter, config registers, hash registers with a
// shared 32x32 multiplier, and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module lhfg_dpath (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire lhfg_pkg::cmd_t                    cmd,
  output lhfg_pkg::status_t                      sts,
  input  wire logic [31:0]                       in_kmer_id,
  input  wire logic                              in_read_start,
  input  wire logic                              in_read_palindromic,
  input  wire logic                              cfg_valid,
  input  wire logic [lhfg_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [lhfg_pkg::CFG_DATA_W-1:0]   cfg_data,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [63:0]                            out_hash_value,
  output logic [31:0]                            out_feature_ordinal,
  output logic [31:0]                            out_bucket_id
);
  import lhfg_pkg::*;

  logic [63:0]         thr_r;
  logic [5:0]          l2_r;
  logic [7:0]          iter_r;
  logic [WIN_BITS-1:0] win_r, win_nxt;
  logic [31:0]         seen_r, seen_nxt;
  logic [63:0]         h_r, k_r;
  logic [63:0]         plo_r;
  logic [31:0]         cross_r;
  logic                out_valid_r;
  logic [63:0]         out_hash_r;
  logic [31:0]         out_ord_r, out_bkt_r;

  logic [63:0]         pair_w;
  logic [31:0]         tail_w;
  logic [SEED_W-1:0]   seed;
  logic [63:0]         mul_a, mul_res;
  logic [31:0]         mul_x, mul_y;
  logic [63:0]         prod;
  logic [31:0]         mask;

  // oldest id in the low bits, newest at the top
  generate
    if (WINDOW_MARKERS > 1) begin : g_shift
      assign win_nxt = {in_kmer_id, win_r[WIN_BITS-1:32]};
    end else begin : g_single
      assign win_nxt = in_kmer_id;
    end
    if (NUM_BLK > 0) begin : g_pair
      assign pair_w = win_r[64*cmd.blk +: 64];
    end else begin : g_nopair
      assign pair_w = '0;
    end
  endgenerate
  assign tail_w = win_r[WIN_BITS-1 -: 32];

  always_comb begin
    if (in_read_start)          seen_nxt = 32'd1;
    else if (seen_r == '1)      seen_nxt = seen_r;
    else                        seen_nxt = seen_r + 32'd1;
  end

  assign sts.go       = !in_read_palindromic && (seen_nxt >= 32'(WINDOW_MARKERS));
  assign sts.low      = (h_r < thr_r);
  assign sts.out_free = !out_valid_r || out_ready;

  assign seed = SEED_W'(iter_r) * SEED_FACTOR;

  // 64x64 low product by the constant, one 32x32 partial product per phase
  assign mul_a   = (cmd.op == OP_MULH) ? h_r : k_r;
  assign mul_x   = (cmd.phase == 2'd1) ? mul_a[63:32] : mul_a[31:0];
  assign mul_y   = (cmd.phase == 2'd2) ? MH_MUL[63:32] : MH_MUL[31:0];
  assign prod    = 64'(mul_x) * 64'(mul_y);
  assign mul_res = {plo_r[63:32] + cross_r + prod[31:0], plo_r[31:0]};

  assign mask = (l2_r >= 6'd32) ? 32'hFFFF_FFFF : ~(32'hFFFF_FFFF << l2_r[4:0]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r  <= '0;
      l2_r   <= LOG2_BUCKETS_RST;
      iter_r <= '0;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_HASH_THRESHOLD) thr_r  <= cfg_data;
      if (cfg_index == CFG_LOG2_BUCKETS)   l2_r   <= cfg_data[5:0];
      if (cfg_index == CFG_ITERATION)      iter_r <= cfg_data[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= '0;
    end else if (cmd.accept) begin
      seen_r <= seen_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) win_r <= win_nxt;
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_MULK || cmd.op == OP_MULH) begin
      if (cmd.phase == 2'd0) plo_r   <= prod;
      if (cmd.phase == 2'd1) cross_r <= prod[31:0];
    end
    unique case (cmd.op)
      OP_INIT:  h_r <= {{(64-SEED_W){1'b0}}, seed} ^ LEN_MUL;
      OP_LOADK: k_r <= pair_w;
      OP_MULK:  if (cmd.phase == 2'd2) k_r <= mul_res;
      OP_XSK:   k_r <= k_r ^ (k_r >> MH_SHIFT);
      OP_XHK:   h_r <= h_r ^ k_r;
      OP_MULH:  if (cmd.phase == 2'd2) h_r <= mul_res;
      OP_TAIL:  h_r <= h_r ^ {32'd0, tail_w};
      OP_XSH:   h_r <= h_r ^ (h_r >> MH_SHIFT);
      default:  ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_hash_r <= h_r;
      out_ord_r  <= seen_r - 32'(WINDOW_MARKERS);
      out_bkt_r  <= h_r[31:0] & mask;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_hash_value      = out_hash_r;
  assign out_feature_ordinal = out_ord_r;
  assign out_bucket_id       = out_bkt_r;

endmodule

`default_nettype wire

// ===== rtl/low_hash_feature_generator.sv =====
// ----------------------------------------------------------------------------
// low_hash_feature_generator
// Sliding-window minhash: MurmurHash64A over the last marker ids of a read,
// emitting features whose hash falls below the configured threshold.
// ----------------------------------------------------------------------------
//  channel   dir   payload                                       word
//  in_ch     in    kmer_id, read_start, read_palindromic         one marker
//  out_ch    out   hash_value, feature_ordinal, bucket_id        one low-hash feature
//  cfg_ch    in    index, data                                   one register write
//
//  A word that completes a feature is hashed after acceptance, paced by
//  the three-phase 64-bit multiply on one shared 32x32 multiplier; other
//  words are accepted without hashing. rst_n is synchronous; config returns
//  to its reset values.
//  A finished result waits in the output register without holding up the
//  next input; only a second result waits for out_ch.ready.
// ----------------------------------------------------------------------------
`default_nettype none

module low_hash_feature_generator (
  input  wire logic clk,
  input  wire logic rst_n,
  lhfg_in_if.sink   in_ch,
  lhfg_out_if.source out_ch,
  lhfg_cfg_if.sink  cfg_ch
);
  import lhfg_pkg::*;

  cmd_t    cmd;
  status_t sts;

  assign cfg_ch.ready = 1'b1;

  lhfg_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  lhfg_dpath u_dpath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .in_kmer_id          (in_ch.kmer_id),
    .in_read_start       (in_ch.read_start),
    .in_read_palindromic (in_ch.read_palindromic),
    .cfg_valid           (cfg_ch.valid),
    .cfg_index           (cfg_ch.index),
    .cfg_data            (cfg_ch.data),
    .out_valid           (out_ch.valid),
    .out_ready           (out_ch.ready),
    .out_hash_value      (out_ch.hash_value),
    .out_feature_ordinal (out_ch.feature_ordinal),
    .out_bucket_id       (out_ch.bucket_id)
  );

endmodule

`default_nettype wire

// ===== dv/lhfg_feature_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lhfg_feature_checker
// Watches the marker, feature and register channels of the low-hash feature
// generator. Keeps its own marker window and MurmurHash64A, works out each
// low-hash feature and compares every feature word field by field.
// ----------------------------------------------------------------------------
module lhfg_feature_checker (
  input  logic clk,
  input  logic rst_n,
  lhfg_in_if   in_mon,
  lhfg_out_if  out_mon,
  lhfg_cfg_if  cfg_mon,
  output int   fail_count,
  output int   pending_count
);
  import lhfg_pkg::*;

  localparam logic [63:0] MURMUR_M  = 64'hc6a4a7935bd1e995;
  localparam int          MURMUR_R  = 47;
  localparam logic [63:0] SEED_STEP = 64'd37;

  typedef struct packed {
    logic [63:0] hash_value;
    logic [31:0] feature_ordinal;
    logic [31:0] bucket_id;
  } feature_t;

  logic [63:0] threshold;
  logic [5:0]  bucket_bits;
  logic [7:0]  iteration;
  logic [31:0] marker_win [WINDOW_MARKERS];
  logic [31:0] markers_in_read;
  feature_t    pending_features [$];

  // window ids oldest first, two ids per 8-byte block, little-endian
  function automatic logic [63:0] window_murmur64(input logic [63:0] seed);
    logic [63:0] h;
    logic [63:0] k;
    int          i;
    h = seed ^ (64'(WINDOW_MARKERS * 4) * MURMUR_M);
    for (i = 0; i + 1 < WINDOW_MARKERS; i += 2) begin
      k = {marker_win[i+1], marker_win[i]};
      k = k * MURMUR_M;
      k ^= k >> MURMUR_R;
      k = k * MURMUR_M;
      h ^= k;
      h = h * MURMUR_M;
    end
    if (i < WINDOW_MARKERS) begin
      h ^= {32'd0, marker_win[i]};
      h = h * MURMUR_M;
    end
    h ^= h >> MURMUR_R;
    h = h * MURMUR_M;
    h ^= h >> MURMUR_R;
    return h;
  endfunction

  function automatic void take_marker(input logic [31:0] id, input logic start,
                                      input logic pal);
    logic [63:0] h;
    logic [31:0] mask;
    feature_t    f;
    if (start) markers_in_read = '0;
    for (int i = 0; i < WINDOW_MARKERS - 1; i++) marker_win[i] = marker_win[i+1];
    marker_win[WINDOW_MARKERS-1] = id;
    // count saturates rather than wrapping
    if (markers_in_read != '1) markers_in_read++;
    if (pal || markers_in_read < 32'(WINDOW_MARKERS)) return;
    h = window_murmur64({56'd0, iteration} * SEED_STEP);
    if (h >= threshold) return;
    mask = (bucket_bits >= 6'd32) ? '1 : 32'((64'd1 << bucket_bits) - 64'd1);
    f.hash_value      = h;
    f.feature_ordinal = markers_in_read - 32'(WINDOW_MARKERS);
    f.bucket_id       = h[31:0] & mask;
    pending_features = {pending_features, f};
  endfunction

  always @(posedge clk) begin : watch
    feature_t want;
    if (!rst_n) begin
      threshold       = '0;
      bucket_bits     = LOG2_BUCKETS_RST;
      iteration       = '0;
      markers_in_read = '0;
      foreach (marker_win[i]) marker_win[i] = '0;
      pending_features.delete();
      fail_count = 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (pending_features.size() == 0) begin
          $error("feature word with none expected: hash_value %h feature_ordinal %0d",
                 out_mon.hash_value, out_mon.feature_ordinal);
          fail_count++;
        end else begin
          want = pending_features.pop_front();
          if (out_mon.hash_value !== want.hash_value) begin
            $error("hash_value: expected %h, got %h", want.hash_value, out_mon.hash_value);
            fail_count++;
          end
          if (out_mon.feature_ordinal !== want.feature_ordinal) begin
            $error("feature_ordinal: expected %0d, got %0d",
                   want.feature_ordinal, out_mon.feature_ordinal);
            fail_count++;
          end
          if (out_mon.bucket_id !== want.bucket_id) begin
            $error("bucket_id: expected %h, got %h", want.bucket_id, out_mon.bucket_id);
            fail_count++;
          end
        end
      end
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          CFG_HASH_THRESHOLD: threshold   = cfg_mon.data;
          CFG_LOG2_BUCKETS:   bucket_bits = cfg_mon.data[5:0];
          CFG_ITERATION:      iteration   = cfg_mon.data[7:0];
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready)
        take_marker(in_mon.kmer_id, in_mon.read_start, in_mon.read_palindromic);
    end
    pending_count <= pending_features.size();
  end

endmodule

// ===== dv/tb_low_hash_feature_generator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_low_hash_feature_generator
// Feeds reads of marker ids through the low-hash feature generator under a
// series of threshold, bucket width and iteration settings, with random
// gaps on the marker side and random back-pressure on the feature side.
// ----------------------------------------------------------------------------
module tb_low_hash_feature_generator;
  import lhfg_pkg::*;

  localparam int ITEM_GOAL     = 1400;
  localparam int RANDOM_PHASES = 5;
  localparam int SETTLE_CYCLES = 40;   // one full hash plus margin
  localparam int QUIET_LIMIT   = 2000;

  logic clk    = 1'b0;
  logic rst_n  = 1'b0;
  logic steady = 1'b0;
  int   fail_count;
  int   pending_count;
  int   items_sent   = 0;
  int   quiet_cycles = 0;

  lhfg_in_if  marker_ch ();
  lhfg_out_if feature_ch ();
  lhfg_cfg_if reg_ch ();

  low_hash_feature_generator DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (marker_ch),
    .out_ch (feature_ch),
    .cfg_ch (reg_ch)
  );

  lhfg_feature_checker checker_i (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mon        (marker_ch),
    .out_mon       (feature_ch),
    .cfg_mon       (reg_ch),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    if ((marker_ch.valid && marker_ch.ready) || (feature_ch.valid && feature_ch.ready) ||
        (reg_ch.valid && reg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    feature_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      feature_ch.ready <= steady || ($urandom_range(0, 99) >= 20);
    end
  end

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_marker(input logic [31:0] id, input logic start, input logic pal);
    while (!steady && $urandom_range(0, 99) < 20) begin
      marker_ch.valid <= 1'b0;
      @(negedge clk);
    end
    marker_ch.valid            <= 1'b1;
    marker_ch.kmer_id          <= id;
    marker_ch.read_start       <= start;
    marker_ch.read_palindromic <= pal;
    @(posedge clk);
    while (!marker_ch.ready) @(posedge clk);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic write_settings(input logic [63:0] thr, input logic [63:0] bits_word,
                                input logic [63:0] iter_word);
    logic [63:0]          words [3];
    logic [CFG_IDX_W-1:0] regs  [3];
    words = '{thr, bits_word, iter_word};
    regs  = '{CFG_HASH_THRESHOLD, CFG_LOG2_BUCKETS, CFG_ITERATION};
    for (int i = 0; i < 3; i++) begin
      reg_ch.valid <= 1'b1;
      reg_ch.index <= regs[i];
      reg_ch.data  <= words[i];
      @(posedge clk);
      while (!reg_ch.ready) @(posedge clk);
      @(negedge clk);
    end
    reg_ch.valid <= 1'b0;
  endtask

  // words that give no feature may still be hashing, hence the extra wait
  task automatic drain_and_settle();
    marker_ch.valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic send_read(input int len, input logic pal);
    logic [31:0] id;
    int          pick;
    for (int n = 0; n < len; n++) begin
      pick = $urandom_range(0, 19);
      id   = (pick == 0) ? 32'd0 : (pick == 1) ? 32'hFFFF_FFFF : 32'($urandom);
      // occasional word with scrambled flags
      if ($urandom_range(0, 19) == 0) send_marker(id, 1'($urandom), 1'($urandom));
      else                            send_marker(id, n == 0, pal);
    end
  endtask

  initial begin
    int phase_end;
    marker_ch.valid            = 1'b0;
    marker_ch.kmer_id          = '0;
    marker_ch.read_start       = 1'b0;
    marker_ch.read_palindromic = 1'b0;
    reg_ch.valid               = 1'b0;
    reg_ch.index               = '0;
    reg_ch.data                = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset threshold of zero lets nothing through
    send_marker(32'hA5A5_0001, 1'b1, 1'b0);
    for (int i = 0; i < 4; i++) send_marker(32'($urandom), 1'b0, 1'b0);
    drain_and_settle();

    write_settings('1, 64'd32, 64'd0);
    // extreme ids, then a palindromic word in mid-read
    send_marker(32'h0000_0000, 1'b1, 1'b0);
    send_marker(32'hFFFF_FFFF, 1'b0, 1'b0);
    send_marker(32'h0000_0000, 1'b0, 1'b0);
    send_marker(32'hFFFF_FFFF, 1'b0, 1'b0);
    send_marker(32'h1234_5678, 1'b0, 1'b0);
    send_marker(32'h8000_0001, 1'b0, 1'b1);
    send_marker(32'h0000_FFFF, 1'b0, 1'b0);
    // short read, then a new read while old ids still sit in the window
    send_marker(32'hDEAD_BEEF, 1'b1, 1'b0);
    send_marker(32'h0000_0001, 1'b0, 1'b0);
    send_marker(32'h7FFF_FFFF, 1'b0, 1'b0);
    send_marker(32'h0F0F_0F0F, 1'b1, 1'b0);
    send_marker(32'hF0F0_F0F0, 1'b0, 1'b0);
    send_marker(32'h5555_5555, 1'b0, 1'b0);
    send_marker(32'hAAAA_AAAA, 1'b0, 1'b0);
    // whole read flagged palindromic
    for (int i = 0; i < 5; i++) send_marker(32'($urandom), i == 0, 1'b1);
    drain_and_settle();

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0: write_settings('1, 64'd0, 64'd255);
        1: write_settings(64'h8000_0000_0000_0000, 64'd32, 64'd0);
        // junk above the register widths
        2: write_settings({$urandom, $urandom} | 64'h4000_0000_0000_0000,
                          {$urandom, $urandom} | 64'h3F, {$urandom, $urandom} | 64'hFF);
        3: write_settings('1, 64'd1, 64'd128);
        default: write_settings({2'b01, 62'({$urandom, $urandom})},
                                64'($urandom_range(2, 31)), 64'($urandom_range(1, 254)));
      endcase
      steady    <= (phase == 3);
      phase_end  = items_sent + (ITEM_GOAL - items_sent) / (RANDOM_PHASES - phase);
      while (items_sent < phase_end)
        send_read(($urandom_range(0, 9) == 0) ? $urandom_range(11, 40) : $urandom_range(1, 10),
                  $urandom_range(0, 9) == 0);
      drain_and_settle();
    end

    if (fail_count == 0) $display("RESULT: OK");
    else                 $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/lhfg_pkg.sv
rtl/lhfg_if.sv
rtl/lhfg_ctrl.sv
rtl/lhfg_dpath.sv
rtl/low_hash_feature_generator.sv
dv/lhfg_feature_checker.sv
dv/tb_low_hash_feature_generator.sv
